// ----- design/lsc_pkg.sv -----
package lsc_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int VIDX_W       = $clog2(VERTEX_COUNT);
  localparam int COORD_BITS   = 32;
  localparam int LEVEL_BITS   = 32;
  localparam int COUNTER_BITS = 16;
  localparam int TOL_BITS     = 16;
  localparam int FRAC_BITS    = 16;
  localparam int NUM_EDGES    = 6;
  localparam int RAM_W        = 3 * COORD_BITS + LEVEL_BITS;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;

  // divider: |level| << FRAC_BITS over |level difference|
  localparam int DVD_W  = LEVEL_BITS + FRAC_BITS;
  localparam int DVS_W  = LEVEL_BITS + 1;
  localparam int DCNT_W = $clog2(DVD_W);
  // multiplier: |coord difference| by 16-bit slices of the ratio
  localparam int MAGD_W   = COORD_BITS + 1;
  localparam int SLICE_W  = 16;
  localparam int NSLICES  = DVD_W / SLICE_W;
  localparam int PROD_W   = MAGD_W + SLICE_W;
  localparam int ACC_W    = MAGD_W + DVD_W;
  localparam int SUM_W    = COORD_BITS + 5;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TETRA = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  typedef logic [3:0][COORD_BITS-1:0] coord4_t;
  typedef logic [3:0][LEVEL_BITS-1:0] level4_t;

  typedef struct packed {
    logic                 is_start;
    logic [NUM_EDGES-1:0] hit;
    coord4_t              px;
    coord4_t              py;
    coord4_t              pz;
    level4_t              pl;
  } job_t;

  function automatic logic [1:0] edge_lo(input logic [2:0] e);
    logic [1:0] v;
    case (e)
      3'd0, 3'd1, 3'd2: v = 2'd0;
      3'd3, 3'd4:       v = 2'd1;
      3'd5:             v = 2'd2;
      default:          v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] edge_hi(input logic [2:0] e);
    logic [1:0] v;
    case (e)
      3'd0:       v = 2'd1;
      3'd1, 3'd3: v = 2'd2;
      3'd2, 3'd4, 3'd5: v = 2'd3;
      default:    v = 2'd1;
    endcase
    return v;
  endfunction

endpackage

// ----- design/lsc_ram.sv -----
module lsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lsc_front.sv -----
module lsc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_opcode,
  input  logic [lsc_pkg::VIDX_W-1:0]    in_vertex_a,
  input  logic [lsc_pkg::VIDX_W-1:0]    in_vertex_b,
  input  logic [lsc_pkg::VIDX_W-1:0]    in_vertex_c,
  input  logic [lsc_pkg::VIDX_W-1:0]    in_vertex_d,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] in_coord_z,
  input  logic signed [lsc_pkg::LEVEL_BITS-1:0] in_level_value,
  input  logic [lsc_pkg::TOL_BITS-1:0]  tol,
  input  logic                          q_full,
  output logic                          q_push,
  output lsc_pkg::job_t                 q_data
);
  import lsc_pkg::*;

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_READ = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [2:0]              cnt_r, cnt_nxt;
  logic [3:0][VIDX_W-1:0]  corner_r;
  coord4_t                 px_r, py_r, pz_r;
  level4_t                 pl_r;

  logic                    acc;
  logic                    ram_we;
  logic [VIDX_W-1:0]       ram_addr;
  logic [RAM_W-1:0]        ram_wdata, ram_rdata;
  logic [NUM_EDGES-1:0]    hit;

  assign full   = (state_r != FS_IDLE) || q_full;
  assign acc    = push && !full;
  assign ram_we = acc && (in_opcode == OP_WRITE);
  assign ram_addr  = ram_we ? in_vertex_a : corner_r[cnt_r[1:0]];
  assign ram_wdata = {in_coord_x, in_coord_y, in_coord_z, in_level_value};

  lsc_ram #(.WIDTH(RAM_W), .DEPTH(VERTEX_COUNT)) u_vtx (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sign-change test against the tolerance band
  always_comb begin
    logic signed [LEVEL_BITS+1:0] tp, tn, li, lj;
    tp = $signed({{(LEVEL_BITS+2-TOL_BITS){1'b0}}, tol});
    tn = -tp;
    for (int e = 0; e < NUM_EDGES; e++) begin
      li = $signed({{2{pl_r[edge_lo(3'(e))][LEVEL_BITS-1]}}, pl_r[edge_lo(3'(e))]});
      lj = $signed({{2{pl_r[edge_hi(3'(e))][LEVEL_BITS-1]}}, pl_r[edge_hi(3'(e))]});
      hit[e] = ((li >= tn) && (lj < tp)) || ((li < tp) && (lj >= tn));
    end
  end

  assign q_push = (acc && (in_opcode == OP_START)) || ((state_r == FS_PUSH) && !q_full);
  always_comb begin
    q_data.is_start = (state_r == FS_IDLE);
    q_data.hit      = hit;
    q_data.px       = px_r;
    q_data.py       = py_r;
    q_data.pz       = pz_r;
    q_data.pl       = pl_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      FS_IDLE: begin
        if (acc && (in_opcode == OP_TETRA)) begin
          state_nxt = FS_READ;
          cnt_nxt   = 3'd0;
        end
      end
      FS_READ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!q_full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (in_opcode == OP_TETRA)) begin
      corner_r <= {in_vertex_d, in_vertex_c, in_vertex_b, in_vertex_a};
    end
    if ((state_r == FS_READ) && (cnt_r != 3'd0)) begin
      px_r[2'(cnt_r - 3'd1)] <= ram_rdata[RAM_W-1 -: COORD_BITS];
      py_r[2'(cnt_r - 3'd1)] <= ram_rdata[RAM_W-1-COORD_BITS -: COORD_BITS];
      pz_r[2'(cnt_r - 3'd1)] <= ram_rdata[LEVEL_BITS+COORD_BITS-1 -: COORD_BITS];
      pl_r[2'(cnt_r - 3'd1)] <= ram_rdata[LEVEL_BITS-1:0];
    end
  end

endmodule

// ----- design/lsc_queue.sv -----
module lsc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  lsc_pkg::job_t wdata,
  output logic          full,
  input  logic          rd,
  output lsc_pkg::job_t rdata,
  output logic          empty
);
  import lsc_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> !full) else $error("write into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> !empty) else $error("read from empty queue");

endmodule

// ----- design/lsc_back.sv -----
module lsc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  lsc_pkg::job_t                   q_data,
  input  logic                            pop,
  output logic                            empty,
  output logic [lsc_pkg::COUNTER_BITS-1:0] out_point_number,
  output logic [lsc_pkg::COUNTER_BITS-1:0] out_facet_number,
  output logic [2:0]                      out_facet_slot,
  output logic signed [lsc_pkg::COORD_BITS-1:0] out_cross_x,
  output logic signed [lsc_pkg::COORD_BITS-1:0] out_cross_y,
  output logic signed [lsc_pkg::COORD_BITS-1:0] out_cross_z,
  output logic                            out_last_point,
  output logic                            out_counter_full
);
  import lsc_pkg::*;

  localparam logic [2:0] BS_IDLE = 3'd0;
  localparam logic [2:0] BS_SCAN = 3'd1;
  localparam logic [2:0] BS_DIV  = 3'd2;
  localparam logic [2:0] BS_MUL  = 3'd3;
  localparam logic [2:0] BS_OUT  = 3'd4;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_BITS-1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd1 <<< (COORD_BITS-1));
  localparam logic [ACC_W-FRAC_BITS-1:0] M_CAP = (ACC_W-FRAC_BITS)'(1) << (COORD_BITS+2);

  logic [2:0]              state_r, state_nxt;
  job_t                    cur_r;
  logic [COUNTER_BITS-1:0] pc_r, pc_nxt, fc_r, fc_nxt, facet_r, facet_nxt;
  logic [2:0]              e_r, e_nxt, slot_r, slot_nxt;
  logic [DCNT_W-1:0]       dcnt_r, dcnt_nxt;
  logic [DVS_W-1:0]        rem_r, rem_nxt;
  logic [DVD_W-1:0]        dvd_r, dvd_nxt;
  logic [DVS_W-1:0]        dvs_r, dvs_nxt;
  logic                    rneg_r, rneg_nxt;
  logic [1:0]              c_r, c_nxt;
  logic [2:0]              step_r, step_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [2:0][COORD_BITS-1:0] res_r, res_nxt;
  logic                    ovalid_r, ovalid_nxt;

  logic [1:0]              lo, hi;
  logic signed [LEVEL_BITS+1:0] li, lj, den;
  logic signed [COORD_BITS+1:0] pi, pj, dd;
  logic [MAGD_W-1:0]       magd;
  logic [SLICE_W-1:0]      slice;
  logic [DVS_W:0]          shv;
  logic [DVS_W+1:0]        trial;
  logic [ACC_W-FRAC_BITS-1:0] mval;
  logic signed [SUM_W-1:0] sum;
  logic                    last;
  logic [COUNTER_BITS-1:0] pc_inc;
  logic                    load_out;

  assign lo  = edge_lo(e_r);
  assign hi  = edge_hi(e_r);
  assign li  = $signed({{2{cur_r.pl[lo][LEVEL_BITS-1]}}, cur_r.pl[lo]});
  assign lj  = $signed({{2{cur_r.pl[hi][LEVEL_BITS-1]}}, cur_r.pl[hi]});
  assign den = lj - li;

  always_comb begin
    logic [COORD_BITS-1:0] a, b;
    case (c_r)
      2'd0:    begin a = cur_r.px[lo]; b = cur_r.px[hi]; end
      2'd1:    begin a = cur_r.py[lo]; b = cur_r.py[hi]; end
      default: begin a = cur_r.pz[lo]; b = cur_r.pz[hi]; end
    endcase
    pi = $signed({{2{a[COORD_BITS-1]}}, a});
    pj = $signed({{2{b[COORD_BITS-1]}}, b});
  end
  assign dd   = pj - pi;
  assign magd = dd[COORD_BITS+1] ? MAGD_W'(-dd) : MAGD_W'(dd);

  always_comb begin
    case (step_r)
      3'd0:    slice = dvd_r[SLICE_W-1:0];
      3'd1:    slice = dvd_r[2*SLICE_W-1:SLICE_W];
      default: slice = dvd_r[3*SLICE_W-1:2*SLICE_W];
    endcase
  end

  assign shv   = {rem_r, dvd_r[DVD_W-1]};
  assign trial = {1'b0, shv} - {2'b00, dvs_r};

  always_comb begin
    logic [ACC_W-FRAC_BITS-1:0] m;
    logic signed [SUM_W-1:0] ms;
    m    = acc_r[ACC_W-1:FRAC_BITS];
    mval = (m > M_CAP) ? M_CAP : m;
    ms   = $signed(SUM_W'(mval));
    if (dd[COORD_BITS+1] != rneg_r) begin
      ms = -ms;
    end
    sum = $signed({{(SUM_W-COORD_BITS){pi[COORD_BITS-1]}}, pi[COORD_BITS-1:0]}) + ms;
  end

  always_comb begin
    last = 1'b1;
    for (int k = 0; k < NUM_EDGES; k++) begin
      if ((3'(k) > e_r) && cur_r.hit[k]) begin
        last = 1'b0;
      end
    end
  end

  assign pc_inc   = (pc_r == CNT_MAX) ? pc_r : pc_r + 1'b1;
  assign load_out = (state_r == BS_OUT) && (!ovalid_r || pop);
  assign q_pop    = (state_r == BS_IDLE) && !q_empty;
  assign empty    = !ovalid_r;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    fc_nxt    = fc_r;
    facet_nxt = facet_r;
    e_nxt     = e_r;
    slot_nxt  = slot_r;
    dcnt_nxt  = dcnt_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    rneg_nxt  = rneg_r;
    c_nxt     = c_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    ovalid_nxt = ovalid_r && !pop;
    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          if (q_data.is_start) begin
            pc_nxt = '0;
            fc_nxt = '0;
          end else begin
            if (q_data.hit != '0) begin
              facet_nxt = fc_r;
              fc_nxt    = (fc_r == CNT_MAX) ? fc_r : fc_r + 1'b1;
            end
            e_nxt     = 3'd0;
            slot_nxt  = 3'd0;
            state_nxt = BS_SCAN;
          end
        end
      end
      BS_SCAN: begin
        if (e_r == 3'(NUM_EDGES)) begin
          state_nxt = BS_IDLE;
        end else if (cur_r.hit[e_r]) begin
          rem_nxt  = '0;
          dvd_nxt  = {(li[LEVEL_BITS+1] ? LEVEL_BITS'(-li) : LEVEL_BITS'(li)),
                      {FRAC_BITS{1'b0}}};
          if (den == '0) begin
            dvs_nxt  = DVS_W'(1);
            rneg_nxt = (li > 0);
          end else begin
            dvs_nxt  = den[LEVEL_BITS+1] ? DVS_W'(-den) : DVS_W'(den);
            rneg_nxt = (li > 0) != den[LEVEL_BITS+1];
          end
          dcnt_nxt  = '0;
          state_nxt = BS_DIV;
        end else begin
          e_nxt = e_r + 3'd1;
        end
      end
      BS_DIV: begin
        if (!trial[DVS_W+1]) begin
          rem_nxt = DVS_W'(trial);
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = DVS_W'(shv);
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DVD_W - 1)) begin
          c_nxt     = 2'd0;
          step_nxt  = 3'd0;
          state_nxt = BS_MUL;
        end
      end
      BS_MUL: begin
        if (step_r < 3'(NSLICES)) begin
          prod_nxt = magd * slice;
        end
        if (step_r == 3'd0) begin
          acc_nxt = '0;
        end else if (step_r <= 3'(NSLICES)) begin
          acc_nxt = acc_r + (ACC_W'(prod_r) << (SLICE_W * (32'(step_r) - 1)));
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(NSLICES + 1)) begin
          if (sum > SAT_HI) begin
            res_nxt[c_r] = SAT_HI[COORD_BITS-1:0];
          end else if (sum < SAT_LO) begin
            res_nxt[c_r] = SAT_LO[COORD_BITS-1:0];
          end else begin
            res_nxt[c_r] = sum[COORD_BITS-1:0];
          end
          step_nxt = 3'd0;
          if (c_r == 2'd2) begin
            state_nxt = BS_OUT;
          end else begin
            c_nxt = c_r + 2'd1;
          end
        end
      end
      BS_OUT: begin
        if (load_out) begin
          ovalid_nxt = 1'b1;
          pc_nxt     = pc_inc;
          slot_nxt   = slot_r + 3'd1;
          e_nxt      = e_r + 3'd1;
          state_nxt  = BS_SCAN;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_IDLE;
      pc_r     <= '0;
      fc_r     <= '0;
      ovalid_r <= 1'b0;
      e_r      <= '0;
      slot_r   <= '0;
      dcnt_r   <= '0;
      c_r      <= '0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      fc_r     <= fc_nxt;
      ovalid_r <= ovalid_nxt;
      e_r      <= e_nxt;
      slot_r   <= slot_nxt;
      dcnt_r   <= dcnt_nxt;
      c_r      <= c_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    facet_r <= facet_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    dvs_r   <= dvs_nxt;
    rneg_r  <= rneg_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    if (load_out) begin
      out_point_number <= pc_r;
      out_facet_number <= facet_r;
      out_facet_slot   <= slot_r;
      out_cross_x      <= res_r[0];
      out_cross_y      <= res_r[1];
      out_cross_z      <= res_r[2];
      out_last_point   <= last;
      out_counter_full <= (pc_inc == CNT_MAX) || (fc_r == CNT_MAX);
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (slot_r < 3'(NUM_EDGES))) else $error("facet slot out of range");
  a_out_hit: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> cur_r.hit[e_r]) else $error("word emitted for an edge without crossing");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !pop) |=> (ovalid_r && $stable(out_point_number)))
    else $error("waiting word overwritten");

endmodule

// ----- design/tetra_level_set_crossing_unit.sv -----
// Zero level-set crossing unit for tetrahedra. Vertex-write words fill a 1024-entry table of
// Q16.16 x, y, z and level values; a tetrahedron word names four table entries and yields one
// result word per edge whose levels change sign within the zero_tolerance band, in edge order
// 01, 02, 03, 12, 13, 23. A start word clears the point and facet counters. The front handles
// vertex writes and start words directly; for a tetrahedron word it makes four table reads
// through the single vertex RAM port. The back then picks the word up, skips each edge without
// a crossing and closes the scan; for each crossing it sets up the ratio, runs the bit-serial
// ratio divider, passes the three coordinates through the shared 33x16 multiplier and loads
// the result register. A two-entry queue separates front and back, and a result register
// separates the back from the result side.
module tetra_level_set_crossing_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      in_opcode,
  input  logic [lsc_pkg::VIDX_W-1:0]      in_vertex_a,
  input  logic [lsc_pkg::VIDX_W-1:0]      in_vertex_b,
  input  logic [lsc_pkg::VIDX_W-1:0]      in_vertex_c,
  input  logic [lsc_pkg::VIDX_W-1:0]      in_vertex_d,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] in_coord_z,
  input  logic signed [lsc_pkg::LEVEL_BITS-1:0] in_level_value,
  output logic                            empty,
  input  logic                            pop,
  output logic [lsc_pkg::COUNTER_BITS-1:0] out_point_number,
  output logic [lsc_pkg::COUNTER_BITS-1:0] out_facet_number,
  output logic [2:0]                      out_facet_slot,
  output logic signed [lsc_pkg::COORD_BITS-1:0] out_cross_x,
  output logic signed [lsc_pkg::COORD_BITS-1:0] out_cross_y,
  output logic signed [lsc_pkg::COORD_BITS-1:0] out_cross_z,
  output logic                            out_last_point,
  output logic                            out_counter_full,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import lsc_pkg::*;

  localparam logic REG_TOL = 1'b0;

  logic [TOL_BITS-1:0] tol_r;
  logic                q_push, q_pop, q_full, q_empty;
  job_t                q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOL) ? {{(32-TOL_BITS){1'b0}}, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_BITS'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOL)) begin
      tol_r <= pwdata[TOL_BITS-1:0];
    end
  end

  lsc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_opcode      (in_opcode),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .in_vertex_c    (in_vertex_c),
    .in_vertex_d    (in_vertex_d),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_level_value (in_level_value),
    .tol            (tol_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  lsc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lsc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_data           (q_rdata),
    .pop              (pop),
    .empty            (empty),
    .out_point_number (out_point_number),
    .out_facet_number (out_facet_number),
    .out_facet_slot   (out_facet_slot),
    .out_cross_x      (out_cross_x),
    .out_cross_y      (out_cross_y),
    .out_cross_z      (out_cross_z),
    .out_last_point   (out_last_point),
    .out_counter_full (out_counter_full)
  );

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_TOL = 3'd0;
  localparam int LIMIT = 1500000;
  localparam int SETTLE = 700;

  typedef struct {
    logic [1:0] op;
    logic [VIDX_W-1:0] va, vb, vc, vd;
    logic signed [31:0] x, y, z, lv;
  } word_t;

  typedef struct {
    logic [COUNTER_BITS-1:0] pnum, fnum;
    logic [2:0] slot;
    logic signed [COORD_BITS-1:0] cx, cy, cz;
    logic last, cfull;
  } crossing_t;

  logic clk = 0;
  logic rst_n = 0;
  logic push, full, empty, pop;
  logic [1:0] in_opcode;
  logic [VIDX_W-1:0] in_vertex_a, in_vertex_b, in_vertex_c, in_vertex_d;
  logic signed [COORD_BITS-1:0] in_coord_x, in_coord_y, in_coord_z;
  logic signed [LEVEL_BITS-1:0] in_level_value;
  logic [COUNTER_BITS-1:0] out_point_number, out_facet_number;
  logic [2:0] out_facet_slot;
  logic signed [COORD_BITS-1:0] out_cross_x, out_cross_y, out_cross_z;
  logic out_last_point, out_counter_full;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  tetra_level_set_crossing_unit dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic signed [31:0] x_tab[VERTEX_COUNT], y_tab[VERTEX_COUNT];
  logic signed [31:0] z_tab[VERTEX_COUNT], lvl_tab[VERTEX_COUNT];
  logic [COUNTER_BITS-1:0] point_ctr, facet_ctr;
  logic [15:0] tol_q;

  word_t pending_words[$];
  crossing_t expected_crossings[$];
  bit written[VERTEX_COUNT];
  int written_ids[$];
  int errors = 0;
  int cycles = 0;
  bit tx_calm = 0, rx_calm = 0, rx_hold_req = 0;
  int rx_hold_cnt = 0, rx_stall = 0, tx_gap = 0;
  word_t cur;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic signed [31:0] lerp_coord(longint p1, longint p2, longint r);
    longint diff, v, sum;
    bit neg;
    logic [63:0] ad, ar;
    logic [127:0] prod, m;
    diff = p2 - p1;
    neg = (diff < 0) != (r < 0);
    ad = (diff < 0) ? -diff : diff;
    ar = (r < 0) ? -r : r;
    prod = {64'd0, ad} * {64'd0, ar};
    m = prod >> 16;
    if (m > (128'd1 << 62)) m = 128'd1 << 62;
    v = neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    sum = p1 + v;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  function automatic void predict_word(word_t w);
    int e_lo[6] = '{0, 0, 0, 1, 1, 2};
    int e_hi[6] = '{1, 2, 3, 2, 3, 3};
    int vid[4];
    longint lv[4], t, li, lj, den, r;
    bit hit[6];
    int cnt, done;
    logic [COUNTER_BITS-1:0] facet;
    crossing_t c;
    if (w.op == OP_WRITE) begin
      x_tab[w.va] = w.x;
      y_tab[w.va] = w.y;
      z_tab[w.va] = w.z;
      lvl_tab[w.va] = w.lv;
      return;
    end
    if (w.op == OP_START) begin
      point_ctr = 0;
      facet_ctr = 0;
      return;
    end
    if (w.op != OP_TETRA) return;
    vid = '{w.va, w.vb, w.vc, w.vd};
    for (int k = 0; k < 4; k++) lv[k] = lvl_tab[vid[k]];
    t = tol_q;
    cnt = 0;
    for (int e = 0; e < 6; e++) begin
      li = lv[e_lo[e]];
      lj = lv[e_hi[e]];
      hit[e] = (li >= -t && lj < t) || (li < t && lj >= -t);
      if (hit[e]) cnt++;
    end
    facet = facet_ctr;
    if (cnt > 0 && facet_ctr != CNT_MAX) facet_ctr++;
    done = 0;
    for (int e = 0; e < 6; e++) begin
      if (!hit[e]) continue;
      li = lv[e_lo[e]];
      lj = lv[e_hi[e]];
      den = lj - li;
      if (den == 0) den = 1;
      r = (-li * 65536) / den;
      c.pnum = point_ctr;
      if (point_ctr != CNT_MAX) point_ctr++;
      c.fnum = facet;
      c.slot = done[2:0];
      c.cx = lerp_coord(x_tab[vid[e_lo[e]]], x_tab[vid[e_hi[e]]], r);
      c.cy = lerp_coord(y_tab[vid[e_lo[e]]], y_tab[vid[e_hi[e]]], r);
      c.cz = lerp_coord(z_tab[vid[e_lo[e]]], z_tab[vid[e_hi[e]]], r);
      c.last = (done == cnt - 1);
      c.cfull = (point_ctr == CNT_MAX || facet_ctr == CNT_MAX);
      expected_crossings.push_back(c);
      done++;
    end
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 0;
    end else begin
      if (push && !full) predict_word(cur);
      if (!push || !full) begin
        if (tx_gap > 0 && !tx_calm) begin
          tx_gap--;
          push <= 0;
        end else if (pending_words.size() > 0) begin
          cur = pending_words.pop_front();
          in_opcode <= cur.op;
          in_vertex_a <= cur.va;
          in_vertex_b <= cur.vb;
          in_vertex_c <= cur.vc;
          in_vertex_d <= cur.vd;
          in_coord_x <= cur.x;
          in_coord_y <= cur.y;
          in_coord_z <= cur.z;
          in_level_value <= cur.lv;
          push <= 1;
          tx_gap = rand_gap();
        end else begin
          push <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    crossing_t c;
    if (!rst_n) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_crossings.size() == 0) begin
          $error("unexpected result word, point_number %0d", out_point_number);
          errors++;
        end else begin
          c = expected_crossings.pop_front();
          check_field("point_number", c.pnum, out_point_number);
          check_field("facet_number", c.fnum, out_facet_number);
          check_field("facet_slot", c.slot, out_facet_slot);
          check_field("cross_x", c.cx, out_cross_x);
          check_field("cross_y", c.cy, out_cross_y);
          check_field("cross_z", c.cz, out_cross_z);
          check_field("last_point", c.last, out_last_point);
          check_field("counter_full", c.cfull, out_counter_full);
        end
      end
      if (rx_hold_req) begin
        rx_hold_cnt = 3000;
        rx_hold_req = 0;
      end
      if (rx_hold_cnt > 0) begin
        rx_hold_cnt--;
        pop <= 0;
      end else if (rx_calm) begin
        pop <= 1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        pop <= 0;
      end else begin
        pop <= 1;
        rx_stall = rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_write(int idx, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic signed [31:0] lv);
    word_t w;
    w = '{OP_WRITE, idx[9:0], 10'($urandom), 10'($urandom), 10'($urandom), x, y, z, lv};
    pending_words.push_back(w);
    if (!written[idx]) begin
      written[idx] = 1;
      written_ids.push_back(idx);
    end
  endtask

  task automatic add_tetra(int a, int b, int c, int d);
    word_t w;
    w = '{OP_TETRA, a[9:0], b[9:0], c[9:0], d[9:0], $urandom, $urandom, $urandom, $urandom};
    pending_words.push_back(w);
  endtask

  task automatic add_other(logic [1:0] op);
    word_t w;
    w = '{op, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
          $urandom, $urandom, $urandom, $urandom};
    pending_words.push_back(w);
  endtask

  function automatic int pick_vertex();
    return written_ids[$urandom_range(written_ids.size() - 1)];
  endfunction

  function automatic logic signed [31:0] rand_level(int t);
    int r;
    logic signed [31:0] v;
    r = $urandom_range(7);
    case (r)
      0: v = $urandom;
      1: v = $signed($urandom_range(2 * t + 4)) - (t + 2);
      2: v = 0;
      3: v = t;
      4: v = -t;
      5: v = ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: begin
        v = $urandom_range(1 << 20);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    int r;
    logic signed [31:0] v;
    r = $urandom_range(9);
    if (r < 3) begin
      v = $urandom;
    end else if (r == 3) begin
      v = ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
    end else begin
      v = $urandom_range(1 << 22);
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  task automatic add_random(int n, int t);
    int r, ids[4];
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        for (int k = 0; k < 4; k++) begin
          ids[k] = $urandom_range(VERTEX_COUNT - 1);
          add_write(ids[k], rand_coord(), rand_coord(), rand_coord(), rand_level(t));
        end
        add_tetra(ids[0], ids[1], ids[2], ids[3]);
      end else if (r < 85) begin
        add_tetra(pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex());
      end else if (r < 92) begin
        add_write($urandom_range(VERTEX_COUNT - 1), rand_coord(), rand_coord(),
                  rand_coord(), rand_level(t));
      end else if (r < 96) begin
        add_other(OP_START);
      end else begin
        add_other(OP_UNUSED);
        i--;
      end
    end
  endtask

  task automatic set_tolerance(logic [15:0] t);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_TOL;
    pwdata <= {16'd0, t};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    tol_q = t;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || push || expected_crossings.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int t;
    push = 0; pop = 0;
    in_opcode = OP_WRITE;
    in_vertex_a = 0; in_vertex_b = 0; in_vertex_c = 0; in_vertex_d = 0;
    in_coord_x = 0; in_coord_y = 0; in_coord_z = 0; in_level_value = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = ADDR_TOL; pwdata = 0;
    point_ctr = 0; facet_ctr = 0; tol_q = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, zero denominators, saturation
    set_tolerance(16'd1);
    tx_calm = 1;
    rx_calm = 1;
    add_write(0, 32'sh80000000, 32'sh7fffffff, 0, 32'sh80000000);
    add_write(1023, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1);
    add_write(5, 32'sh00010000, -32'sh00020000, 32'sh00030000, 32'sh7fffffff);
    add_write(6, -32'sh00050000, 32'sh00070000, 0, -32'sh00008000);
    add_tetra(0, 1023, 5, 6);
    add_write(10, 32'sh00100000, 0, -32'sh00100000, 0);
    add_write(11, -32'sh00100000, 32'sh00200000, 0, 0);
    add_write(12, 0, -32'sh00300000, 32'sh00100000, 0);
    add_write(13, 32'sh7fffffff, 32'sh80000000, 32'sh12345678, 0);
    add_tetra(10, 11, 12, 13);
    add_tetra(5, 5, 5, 5);
    add_tetra(0, 5, 0, 5);
    add_tetra(1023, 0, 6, 13);
    add_other(OP_UNUSED);
    add_other(OP_START);
    add_tetra(13, 12, 11, 10);
    add_tetra(6, 10, 1023, 0);
    wait_idle();

    set_tolerance(16'd0);
    tx_calm = 0;
    rx_calm = 0;
    add_tetra(10, 11, 12, 13);
    add_random(10, 0);
    wait_idle();

    set_tolerance(16'hffff);
    add_write(20, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 60000);
    add_write(21, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 59999);
    add_tetra(20, 21, 20, 21);
    rx_hold_req = 1;
    for (int i = 0; i < 12; i++)
      add_tetra(10, 11, pick_vertex(), pick_vertex());
    add_random(10, 65535);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      t = (ph == 0) ? $urandom_range(16) : $urandom_range(65535);
      set_tolerance(t[15:0]);
      tx_calm = (ph == 1);
      rx_calm = (ph == 2);
      add_random(12, t);
      wait_idle();
    end

    if (errors == 0 && expected_crossings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/lsc_pkg.sv
design/lsc_ram.sv
design/lsc_front.sv
design/lsc_queue.sv
design/lsc_back.sv
design/tetra_level_set_crossing_unit.sv
tb/sv/tb.sv
